// ===== sv/qrc_pkg.sv =====
// Package for the queue reconstruction block: beat types and sizing constants.
// No dependencies.
package qrc_pkg;
	localparam int MaxPeople = 64;

	typedef struct packed {
		logic [15:0] height;
		logic [7:0]  ahead_count;
		logic        is_last;
	} in_beat_t;

	typedef struct packed {
		logic [15:0] out_height;
		logic [7:0]  out_ahead_count;
		logic        out_last;
		logic        overflow;
	} out_beat_t;

	typedef struct packed {
		logic [15:0] height;
		logic [7:0]  count;
	} pair_t;
endpackage

// ===== sv/qrc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module qrc_ram #(
	parameter int Width = 24,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// ===== sv/queue_reconstruction_by_count_top.sv =====
// Top level of the queue reconstruction block: loader, sequencer and output stage.
// Depends on qrc_pkg and qrc_ram.
//
// Usage: pairs arrive on the in channel (in_valid/in_ready, payload in_data),
// one beat per cycle while loading. A beat with is_last starts the computation
// and in_ready stays low until the whole queue has been handed to the output
// register. Pairs beyond MAX_PEOPLE are dropped and every result of that set
// carries overflow. Ordering is an insertion sort through one shared compare
// unit on the load RAM: each pair is read and latched as the key, elements
// it goes before are moved up until a compare stops the move or the front is
// reached, and the key is written. Building the queue fetches each pair,
// scans the queue positions, starts the shift, then shifts or writes each
// position. Output then drains from a one-entry output register, holding
// while out_ready is low, and then returns to loading.
// Reset empties the loader and returns to loading; no RAM clearing is needed.
module queue_reconstruction_by_count_top #(
	parameter int MAX_PEOPLE = qrc_pkg::MaxPeople
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  qrc_pkg::in_beat_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output qrc_pkg::out_beat_t out_data
);
	localparam int AW = $clog2(MAX_PEOPLE);
	localparam int LW = $clog2(MAX_PEOPLE + 1);
	localparam int CW = (LW > 8) ? LW : 8;

	typedef enum logic [11:0] {
		LOAD   = 12'b000000000001,
		S_RD   = 12'b000000000010,
		S_KEY  = 12'b000000000100,
		S_CMP  = 12'b000000001000,
		S_WR   = 12'b000000010000,
		B_RDP  = 12'b000000100000,
		B_LATP = 12'b000001000000,
		B_SCHK = 12'b000010000000,
		B_SHRD = 12'b000100000000,
		B_SHWR = 12'b001000000000,
		O_RD   = 12'b010000000000,
		O_WAIT = 12'b100000000000
	} state_t;

	state_t state_q;
	logic [LW-1:0] len_q, i_q, j_q, qlen_q, k_q, pos_q, seen_q;
	logic drop_q;
	qrc_pkg::pair_t key_q, p_q;

	// Load RAM signals.
	logic la_we;
	logic [AW-1:0] la_wa, la_ra;
	qrc_pkg::pair_t la_wd, la_rd;
	// Queue RAM signals.
	logic qa_we;
	logic [AW-1:0] qa_wa, qa_ra;
	qrc_pkg::pair_t qa_wd, qa_rd;

	qrc_ram #(.Width($bits(qrc_pkg::pair_t)), .Depth(MAX_PEOPLE)) u_load (
		.clk(clk), .we(la_we), .waddr(la_wa), .wdata(la_wd), .raddr(la_ra), .rdata(la_rd)
	);
	qrc_ram #(.Width($bits(qrc_pkg::pair_t)), .Depth(MAX_PEOPLE)) u_queue (
		.clk(clk), .we(qa_we), .waddr(qa_wa), .wdata(qa_wd), .raddr(qa_ra), .rdata(qa_rd)
	);

	logic in_acc;
	logic first;
	logic hit;
	assign in_ready = (state_q == LOAD);
	assign in_acc = in_valid && in_ready;
	// Shared compare: key goes before the element just read.
	assign first = (key_q.count != la_rd.count) ? (key_q.count < la_rd.count)
		: (key_q.height > la_rd.height);
	// The queue entry just read is at least as tall as the pair being placed.
	assign hit = (qa_rd.height >= p_q.height);

	always_comb begin
		la_we = 1'b0;
		la_wa = len_q[AW-1:0];
		la_wd = '{height: in_data.height, count: in_data.ahead_count};
		la_ra = '0;
		qa_we = 1'b0;
		qa_wa = k_q[AW-1:0];
		qa_wd = qa_rd;
		qa_ra = '0;
		case (state_q)
			LOAD: la_we = in_acc && (len_q < LW'(MAX_PEOPLE));
			S_RD: la_ra = i_q[AW-1:0];
			S_KEY: la_ra = AW'(i_q - 1'b1);
			S_CMP: begin
				// Move the element the key goes before up while reading the next one down.
				la_ra = AW'(j_q - 2'd2);
				la_we = first;
				la_wa = j_q[AW-1:0];
				la_wd = la_rd;
			end
			S_WR: begin
				la_we = 1'b1;
				la_wa = j_q[AW-1:0];
				la_wd = key_q;
			end
			B_RDP: la_ra = i_q[AW-1:0];
			B_SCHK: qa_ra = AW'(k_q + 1'b1);
			B_SHRD: qa_ra = AW'(k_q - 1'b1);
			B_SHWR: begin
				qa_we = 1'b1;
				qa_ra = AW'(k_q - 2'd2);
				if (k_q == pos_q) qa_wd = p_q;
			end
			O_RD: qa_ra = k_q[AW-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LOAD;
			len_q <= '0;
			drop_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			qlen_q <= '0;
			k_q <= '0;
			pos_q <= '0;
			seen_q <= '0;
			key_q <= '0;
			p_q <= '0;
			out_valid <= 1'b0;
			out_data <= '0;
		end else begin
			if (state_q == O_WAIT) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			case (state_q)
				LOAD: if (in_acc) begin
					if (len_q < LW'(MAX_PEOPLE)) len_q <= len_q + 1'b1;
					else drop_q <= 1'b1;
					if (in_data.is_last) begin
						i_q <= LW'(1);
						state_q <= S_RD;
					end
				end
				S_RD: begin
					if (i_q >= len_q) begin
						i_q <= '0;
						qlen_q <= '0;
						state_q <= B_RDP;
					end else state_q <= S_KEY;
				end
				S_KEY: begin
					key_q <= la_rd;
					j_q <= i_q;
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (first) begin
						j_q <= j_q - 1'b1;
						if (j_q == LW'(1)) state_q <= S_WR;
					end else state_q <= S_WR;
				end
				S_WR: begin
					i_q <= i_q + 1'b1;
					state_q <= S_RD;
				end
				B_RDP: begin
					if (i_q >= len_q) begin
						k_q <= '0;
						state_q <= O_RD;
					end else state_q <= B_LATP;
				end
				B_LATP: begin
					p_q <= la_rd;
					k_q <= '0;
					seen_q <= '0;
					if (qlen_q == '0) begin
						pos_q <= '0;
						state_q <= B_SHRD;
					end else state_q <= B_SCHK;
				end
				B_SCHK: begin
					// The pair goes before the entry that pushes the count past its own.
					if (hit && CW'(seen_q) >= CW'(p_q.count)) begin
						pos_q <= k_q;
						k_q <= qlen_q;
						state_q <= B_SHRD;
					end else if (k_q + 1'b1 >= qlen_q) begin
						pos_q <= qlen_q;
						k_q <= qlen_q;
						state_q <= B_SHRD;
					end else begin
						k_q <= k_q + 1'b1;
						if (hit) seen_q <= seen_q + 1'b1;
					end
				end
				B_SHRD: state_q <= B_SHWR;
				B_SHWR: begin
					if (k_q == pos_q) begin
						qlen_q <= qlen_q + 1'b1;
						i_q <= i_q + 1'b1;
						state_q <= B_RDP;
					end else k_q <= k_q - 1'b1;
				end
				O_RD: if (!out_valid || out_ready) begin
					if (k_q >= qlen_q) begin
						len_q <= '0;
						drop_q <= 1'b0;
						state_q <= LOAD;
					end else state_q <= O_WAIT;
				end
				O_WAIT: begin
					out_data <= '{out_height: qa_rd.height, out_ahead_count: qa_rd.count,
						out_last: (k_q + 1'b1 == qlen_q), overflow: drop_q};
					k_q <= k_q + 1'b1;
					state_q <= O_RD;
				end
				default: ;
			endcase
		end
	end
endmodule
